// ===== rtl/key_min_hold_stretcher_assert.svh =====
// ---------------------------------------------------------------------------
// key_min_hold_stretcher_assert.svh
// Assertion macros for the key minimum hold stretcher
// ---------------------------------------------------------------------------
`ifndef KEY_MIN_HOLD_STRETCHER_ASSERT_SVH
`define KEY_MIN_HOLD_STRETCHER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define KMH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define KMH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KMH_ASSERT_IMP(label, ante, cons, msg)
`define KMH_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/kmh_pkg.sv =====
// ---------------------------------------------------------------------------
// kmh_pkg
// Types and constants shared by the key minimum hold stretcher
// ---------------------------------------------------------------------------
`default_nettype none

package kmh_pkg;

    // default number of key slots
    localparam int DEF_SLOTS = 64;

    // most key-ups one tick may release
    localparam int RESULT_LIMIT = 64;
    localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

    // reset value of the minimum hold
    localparam logic [15:0] MIN_HOLD_RST = 16'd50;

    // opcodes
    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // slot modes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_HELD    = 2'd1;
    localparam logic [1:0] MODE_PENDING = 2'd2;

    // input item
    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  key_slot;
        logic [31:0] key_code;
        logic [31:0] now_ms;
    } item_t;

    // result item
    typedef struct packed {
        logic [31:0] out_code;
        logic [5:0]  out_slot;
        logic        is_down;
        logic        last_of_run;
    } result_t;

    // state of one key slot
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] press_time;
        logic [31:0] held_code;
    } entry_t;

    // edge found by the head unit
    typedef struct packed {
        logic        valid;
        logic [31:0] code;
        logic        is_down;
    } head_res_t;

endpackage

`default_nettype wire

// ===== rtl/kmh_cell.sv =====
// ---------------------------------------------------------------------------
// kmh_cell
// One slot of the rotating state ring, loads its neighbor's entry on shift
// ---------------------------------------------------------------------------
`default_nettype none

module kmh_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift,
    input  wire kmh_pkg::entry_t d_in,
    output kmh_pkg::entry_t      q
);
    import kmh_pkg::*;

    logic [1:0]  mode_reg;
    logic [31:0] time_reg;
    logic [31:0] code_reg;

    // mode is control state, cleared to idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
        end
        else if (shift)
        begin
            mode_reg <= d_in.mode;
        end
    end

    // press time and keycode, meaningful only when not idle
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            time_reg <= d_in.press_time;
            code_reg <= d_in.held_code;
        end
    end

    assign q = '{mode: mode_reg, press_time: time_reg, held_code: code_reg};

endmodule

`default_nettype wire

// ===== rtl/kmh_head.sv =====
// ---------------------------------------------------------------------------
// kmh_head
// Update unit at the ring's wrap point: applies the item to the slot passing by
// ---------------------------------------------------------------------------
`default_nettype none

module kmh_head (
    input  wire kmh_pkg::item_t  cmd,
    input  wire logic            hit,
    input  wire logic            lim_ok,
    input  wire logic [15:0]     min_hold,
    input  wire kmh_pkg::entry_t cur,
    output kmh_pkg::entry_t      nxt,
    output kmh_pkg::head_res_t   res
);
    import kmh_pkg::*;

    logic [31:0] elapsed;
    logic        reached;

    // elapsed time wraps modulo 2^32
    assign elapsed = cmd.now_ms - cur.press_time;
    assign reached = (elapsed >= {16'd0, min_hold});

    // per-opcode slot update
    always_comb
    begin
        nxt         = cur;
        res.valid   = 1'b0;
        res.code    = cur.held_code;
        res.is_down = 1'b0;
        unique case (cmd.opcode)
            OP_PRESS:
            begin
                if (hit && (cur.mode == MODE_PENDING))
                begin
                    nxt.mode = MODE_HELD;
                end
                else if (hit && (cur.mode == MODE_IDLE))
                begin
                    nxt.mode       = MODE_HELD;
                    nxt.press_time = cmd.now_ms;
                    nxt.held_code  = cmd.key_code;
                    res.valid      = 1'b1;
                    res.code       = cmd.key_code;
                    res.is_down    = 1'b1;
                end
            end
            OP_RELEASE:
            begin
                if (hit && (cur.mode == MODE_HELD))
                begin
                    if (reached)
                    begin
                        nxt.mode  = MODE_IDLE;
                        res.valid = 1'b1;
                    end
                    else
                    begin
                        nxt.mode = MODE_PENDING;
                    end
                end
            end
            OP_TICK:
            begin
                if ((cur.mode == MODE_PENDING) && reached && lim_ok)
                begin
                    nxt.mode  = MODE_IDLE;
                    res.valid = 1'b1;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/key_min_hold_stretcher.sv =====
// ---------------------------------------------------------------------------
// key_min_hold_stretcher
// Per-key minimum hold stretcher built as a rotating ring of slot cells
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// cmd       in         start && !busy       item_t (opcode, slot, code, time)
// result    out        strobe, one cycle    result_t (code, slot, down, last)
// cfg       in         cfg_we               cfg_wdata = minimum hold in ms
//
// busy stays high while an item runs: the ring turns once past the head unit,
// one slot a cycle, then the flush state releases the held-back last edge.
// an edge waits until the next one is found or the scan ends, then is strobed
// in the cycle after; the last edge comes in the cycle after busy falls, and a
// new item can be taken as soon as busy falls.
// reset clears all slots to idle and the minimum hold to 50; no receiver stall.
// ---------------------------------------------------------------------------
`default_nettype none
`include "key_min_hold_stretcher_assert.svh"

module key_min_hold_stretcher #(
    parameter int SLOTS = kmh_pkg::DEF_SLOTS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire kmh_pkg::item_t   cmd,
    input  wire logic             cfg_we,
    input  wire logic [15:0]      cfg_wdata,
    output logic                  strobe,
    output kmh_pkg::result_t      result
);
    import kmh_pkg::*;

    localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [SlotW-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pend_valid_reg, pend_valid_next;
    result_t          pend_reg, pend_next;
    item_t            cmd_reg;
    logic [15:0]      min_reg;
    logic             strobe_reg, strobe_next;
    result_t          result_reg, result_next;

    entry_t           cell_q [SLOTS];
    entry_t           cell_d [SLOTS];
    entry_t           head_nxt;
    head_res_t        head_res;
    logic             shift;
    logic             hit;
    logic             lim_ok;
    logic             accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign shift  = (state_reg == ST_SCAN);
    assign hit    = (32'(cmd_reg.key_slot) == 32'(idx_reg));
    assign lim_ok = (cnt_reg < CNT_W'(RESULT_LIMIT));

    // ring of slot cells, rotating toward cell 0
    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            if (gi == SLOTS - 1)
            begin : g_wrap
                assign cell_d[gi] = head_nxt;
            end
            else
            begin : g_link
                assign cell_d[gi] = cell_q[gi + 1];
            end
            kmh_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d_in  (cell_d[gi]),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    // head unit sees the slot leaving cell 0
    kmh_head u_head (
        .cmd      (cmd_reg),
        .hit      (hit),
        .lim_ok   (lim_ok),
        .min_hold (min_reg),
        .cur      (cell_q[0]),
        .nxt      (head_nxt),
        .res      (head_res)
    );

    // sequencer: scan the ring, hold back one edge to mark the last
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        strobe_next     = 1'b0;
        result_next     = pend_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next      = ST_SCAN;
                    idx_next        = '0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (head_res.valid)
                begin
                    strobe_next             = pend_valid_reg;
                    result_next.last_of_run = 1'b0;
                    pend_valid_next         = 1'b1;
                    pend_next.out_code      = head_res.code;
                    pend_next.out_slot      = 6'(idx_reg);
                    pend_next.is_down       = head_res.is_down;
                    pend_next.last_of_run   = 1'b0;
                    cnt_next                = cnt_reg + 1'b1;
                end
                if (idx_reg == SlotW'(SLOTS - 1))
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FLUSH:
            begin
                strobe_next             = pend_valid_reg;
                result_next.last_of_run = 1'b1;
                pend_valid_next         = 1'b0;
                state_next              = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            min_reg        <= MIN_HOLD_RST;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
            if (cfg_we)
            begin
                min_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    // checks
    `KMH_ASSERT_NXT(a_no_strobe_idle, state_reg == ST_IDLE, !strobe, "strobe after idle cycle")
    `KMH_ASSERT_IMP(a_last_ends, strobe && result.last_of_run, state_reg == ST_IDLE, "last edge before end of item")
    `KMH_ASSERT_IMP(a_mid_edge, strobe && !result.last_of_run, state_reg != ST_IDLE, "item ended without last edge")
    `KMH_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted item did not start")

endmodule

`default_nettype wire
